/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define EOG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eog same-cycle check failed");

// When ante holds at a clock edge, cons must hold at the next edge.
`define EOG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eog next-cycle check failed");

`endif

/* rtl/core/eog_pkg.sv */
// Package for the opcode group 0x20-0x3F executor: opcodes, operation kinds,
// flag positions, queue sizing and the queue entry type. Depends on nothing.
package eog_pkg;

   // Opcodes of the executed row.
   localparam logic [7:0] OPC_JR_NZ     = 8'h20;
   localparam logic [7:0] OPC_LD_HL_IMM = 8'h21;
   localparam logic [7:0] OPC_LDI_MEM_A = 8'h22;
   localparam logic [7:0] OPC_INC_HL16  = 8'h23;
   localparam logic [7:0] OPC_INC_H     = 8'h24;
   localparam logic [7:0] OPC_DEC_H     = 8'h25;
   localparam logic [7:0] OPC_LD_H_IMM  = 8'h26;
   localparam logic [7:0] OPC_DAA       = 8'h27;
   localparam logic [7:0] OPC_JR_Z      = 8'h28;
   localparam logic [7:0] OPC_ADD_HL_HL = 8'h29;
   localparam logic [7:0] OPC_LDI_A_MEM = 8'h2A;
   localparam logic [7:0] OPC_DEC_HL16  = 8'h2B;
   localparam logic [7:0] OPC_INC_L     = 8'h2C;
   localparam logic [7:0] OPC_DEC_L     = 8'h2D;
   localparam logic [7:0] OPC_LD_L_IMM  = 8'h2E;
   localparam logic [7:0] OPC_CPL       = 8'h2F;
   localparam logic [7:0] OPC_JR_NC     = 8'h30;
   localparam logic [7:0] OPC_LD_SP_IMM = 8'h31;
   localparam logic [7:0] OPC_LDD_MEM_A = 8'h32;
   localparam logic [7:0] OPC_INC_SP    = 8'h33;
   localparam logic [7:0] OPC_INC_MEM   = 8'h34;
   localparam logic [7:0] OPC_DEC_MEM   = 8'h35;
   localparam logic [7:0] OPC_LD_MEM_IMM = 8'h36;
   localparam logic [7:0] OPC_SCF       = 8'h37;
   localparam logic [7:0] OPC_JR_C      = 8'h38;
   localparam logic [7:0] OPC_ADD_HL_SP = 8'h39;
   localparam logic [7:0] OPC_LDD_A_MEM = 8'h3A;
   localparam logic [7:0] OPC_DEC_SP    = 8'h3B;
   localparam logic [7:0] OPC_INC_A     = 8'h3C;
   localparam logic [7:0] OPC_DEC_A     = 8'h3D;
   localparam logic [7:0] OPC_LD_A_IMM  = 8'h3E;
   localparam logic [7:0] OPC_CCF       = 8'h3F;

   // Flag positions inside the 4-bit flag word.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants.
   localparam logic [7:0] DAA_LIMIT     = 8'h99;
   localparam logic [7:0] DAA_HI_ADJ    = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ    = 8'h06;
   localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;

   // Machine cycle counts.
   localparam logic [1:0] CYC_NONE = 2'd0;
   localparam logic [1:0] CYC_ONE  = 2'd1;
   localparam logic [1:0] CYC_TWO  = 2'd2;
   localparam logic [1:0] CYC_THREE = 2'd3;

   // Queue between decode and execute.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   typedef enum logic [4:0] {
      OP_NONE, OP_JR, OP_LD_HL_IMM, OP_LDI_MEM_A, OP_INC_HL16, OP_INC_H, OP_DEC_H,
      OP_LD_H_IMM, OP_DAA, OP_ADD_HL_HL, OP_LDI_A_MEM, OP_DEC_HL16, OP_INC_L,
      OP_DEC_L, OP_LD_L_IMM, OP_CPL, OP_LD_SP_IMM, OP_LDD_MEM_A, OP_INC_SP,
      OP_INC_MEM, OP_DEC_MEM, OP_LD_MEM_IMM, OP_SCF, OP_ADD_HL_SP, OP_LDD_A_MEM,
      OP_DEC_SP, OP_INC_A, OP_DEC_A, OP_LD_A_IMM, OP_CCF
   } op_kind_type;

   // Jump conditions, in the order of opcode bits 4:3.
   typedef enum logic [1:0] {CC_NZ, CC_Z, CC_NC, CC_C} cond_type;

   // One decoded item as it waits for execution.
   typedef struct packed {
      op_kind_type kind;
      cond_type    cond;
      logic [1:0]  cycles;
      logic [7:0]  imm8;
      logic [15:0] imm16;
      logic [15:0] pc_in;
      logic [15:0] jr_target;
      logic [7:0]  mem_read_value;
   } q_entry_type;

endpackage

/* rtl/core/eog_ifs.sv */
// Handshake channel interfaces for the request and response sides.
// Depends on nothing.
interface eog_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  action;
   logic [7:0]  imm8;
   logic [15:0] imm16;
   logic [15:0] pc_in;
   logic [7:0]  mem_read_value;

   modport source (output valid, action, imm8, imm16, pc_in, mem_read_value,
                   input ready);
   modport sink (input valid, action, imm8, imm16, pc_in, mem_read_value,
                 output ready);
endinterface

interface eog_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pc_out;
   logic [15:0] mem_addr;
   logic        mem_write_en;
   logic [7:0]  mem_write_data;
   logic [1:0]  machine_cycles;
   logic        recognized;
   logic [7:0]  accumulator;
   logic [15:0] hl_pair;
   logic [15:0] stack_ptr;
   logic [3:0]  flag_bits;

   modport source (output valid, pc_out, mem_addr, mem_write_en, mem_write_data,
                   machine_cycles, recognized, accumulator, hl_pair, stack_ptr,
                   flag_bits, input ready);
   modport sink (input valid, pc_out, mem_addr, mem_write_en, mem_write_data,
                 machine_cycles, recognized, accumulator, hl_pair, stack_ptr,
                 flag_bits, output ready);
endinterface

/* rtl/core/eog_front.sv */
// Front end: accepts request items, decodes the opcode into an operation kind
// and precomputes the jump target. Depends on eog_pkg and eog_ifs.
module eog_front (
   eog_req_if.sink            req_if,
   input  logic               queue_full,
   output logic               push,
   output eog_pkg::q_entry_type push_entry
);

   eog_pkg::op_kind_type kind;
   logic [1:0]           cycles;
   logic [15:0]          offset;

   // Accept whenever the queue has room.
   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   // Opcode decode with the base cycle count.
   always_comb begin
      kind   = eog_pkg::OP_NONE;
      cycles = eog_pkg::CYC_NONE;
      case (req_if.action)
         eog_pkg::OPC_JR_NZ, eog_pkg::OPC_JR_Z,
         eog_pkg::OPC_JR_NC, eog_pkg::OPC_JR_C: begin
            kind = eog_pkg::OP_JR;         cycles = eog_pkg::CYC_TWO;
         end
         eog_pkg::OPC_LD_HL_IMM: begin kind = eog_pkg::OP_LD_HL_IMM; cycles = eog_pkg::CYC_THREE; end
         eog_pkg::OPC_LDI_MEM_A: begin kind = eog_pkg::OP_LDI_MEM_A; cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_INC_HL16:  begin kind = eog_pkg::OP_INC_HL16;  cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_INC_H:     begin kind = eog_pkg::OP_INC_H;     cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_DEC_H:     begin kind = eog_pkg::OP_DEC_H;     cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_LD_H_IMM:  begin kind = eog_pkg::OP_LD_H_IMM;  cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_DAA:       begin kind = eog_pkg::OP_DAA;       cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_ADD_HL_HL: begin kind = eog_pkg::OP_ADD_HL_HL; cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_LDI_A_MEM: begin kind = eog_pkg::OP_LDI_A_MEM; cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_DEC_HL16:  begin kind = eog_pkg::OP_DEC_HL16;  cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_INC_L:     begin kind = eog_pkg::OP_INC_L;     cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_DEC_L:     begin kind = eog_pkg::OP_DEC_L;     cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_LD_L_IMM:  begin kind = eog_pkg::OP_LD_L_IMM;  cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_CPL:       begin kind = eog_pkg::OP_CPL;       cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_LD_SP_IMM: begin kind = eog_pkg::OP_LD_SP_IMM; cycles = eog_pkg::CYC_THREE; end
         eog_pkg::OPC_LDD_MEM_A: begin kind = eog_pkg::OP_LDD_MEM_A; cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_INC_SP:    begin kind = eog_pkg::OP_INC_SP;    cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_INC_MEM:   begin kind = eog_pkg::OP_INC_MEM;   cycles = eog_pkg::CYC_THREE; end
         eog_pkg::OPC_DEC_MEM:   begin kind = eog_pkg::OP_DEC_MEM;   cycles = eog_pkg::CYC_THREE; end
         eog_pkg::OPC_LD_MEM_IMM: begin
            kind = eog_pkg::OP_LD_MEM_IMM; cycles = eog_pkg::CYC_THREE;
         end
         eog_pkg::OPC_SCF:       begin kind = eog_pkg::OP_SCF;       cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_ADD_HL_SP: begin kind = eog_pkg::OP_ADD_HL_SP; cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_LDD_A_MEM: begin kind = eog_pkg::OP_LDD_A_MEM; cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_DEC_SP:    begin kind = eog_pkg::OP_DEC_SP;    cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_INC_A:     begin kind = eog_pkg::OP_INC_A;     cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_DEC_A:     begin kind = eog_pkg::OP_DEC_A;     cycles = eog_pkg::CYC_ONE; end
         eog_pkg::OPC_LD_A_IMM:  begin kind = eog_pkg::OP_LD_A_IMM;  cycles = eog_pkg::CYC_TWO; end
         eog_pkg::OPC_CCF:       begin kind = eog_pkg::OP_CCF;       cycles = eog_pkg::CYC_ONE; end
         default: begin
            kind   = eog_pkg::OP_NONE;
            cycles = eog_pkg::CYC_NONE;
         end
      endcase
   end

   // The jump target depends only on the item, so it is formed here.
   assign offset = {{8{req_if.imm8[7]}}, req_if.imm8};

   always_comb begin
      push_entry.kind           = kind;
      push_entry.cond           = eog_pkg::cond_type'(req_if.action[4:3]);
      push_entry.cycles         = cycles;
      push_entry.imm8           = req_if.imm8;
      push_entry.imm16          = req_if.imm16;
      push_entry.pc_in          = req_if.pc_in;
      push_entry.jr_target      = req_if.pc_in + offset;
      push_entry.mem_read_value = req_if.mem_read_value;
   end

endmodule

/* rtl/core/eog_queue.sv */
// Short FIFO of decoded items between the front end and the execute stage.
// Depends on eog_pkg.
module eog_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  eog_pkg::q_entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                q_valid,
   output eog_pkg::q_entry_type q_entry
);

   eog_pkg::q_entry_type                 store_ff [eog_pkg::QUEUE_DEPTH];
   logic [eog_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [eog_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [eog_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;

   assign full    = (count_ff == eog_pkg::QUEUE_CNT_W'(eog_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = store_ff[rd_ptr_ff];

   // Pointer and fill count update; push and pop may share a cycle.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + eog_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + eog_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + eog_pkg::QUEUE_CNT_W'(push) - eog_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/eog_back.sv */
// Execute stage: holds A, HL, SP and flags, carries out one decoded item per
// cycle unless the response stalls, and registers the response. Depends on eog_pkg and eog_ifs.
module eog_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  eog_pkg::q_entry_type q_entry,
   output logic                pop,
   eog_rsp_if.source           rsp_if
);

   // Architectural state.
   logic [7:0]  a_ff, a_in;
   logic [7:0]  h_ff, l_ff;
   logic [15:0] sp_ff, sp_in;
   logic [3:0]  flags_ff, flags_in;

   // Response register.
   logic        valid_ff, valid_in;
   logic [15:0] pc_out_ff, mem_addr_ff, hl_out_ff, sp_out_ff;
   logic        wen_ff, rec_ff;
   logic [7:0]  wdata_ff, a_out_ff;
   logic [1:0]  cyc_ff;
   logic [3:0]  flags_out_ff;

   // Execute results.
   logic [15:0] hl, hl_in, pc_next;
   logic        wen;
   logic [7:0]  wdata;
   logic [1:0]  cyc;
   logic        taken;
   logic [7:0]  idu_opnd, idu_res;
   logic        idu_dec, idu_half;
   logic [15:0] add_b;
   logic [16:0] add_sum;
   logic [12:0] add_low;
   logic [7:0]  daa_val;
   logic        daa_c;

   assign hl  = {h_ff, l_ff};
   assign pop = q_valid && (!valid_ff || rsp_if.ready);

   // Jump condition from the current flags.
   always_comb begin
      case (q_entry.cond)
         eog_pkg::CC_NZ: taken = !flags_ff[eog_pkg::FLAG_Z];
         eog_pkg::CC_Z:  taken = flags_ff[eog_pkg::FLAG_Z];
         eog_pkg::CC_NC: taken = !flags_ff[eog_pkg::FLAG_C];
         eog_pkg::CC_C:  taken = flags_ff[eog_pkg::FLAG_C];
         default:        taken = 1'b0;
      endcase
   end

   // Shared 8-bit increment/decrement unit.
   always_comb begin
      case (q_entry.kind)
         eog_pkg::OP_INC_H, eog_pkg::OP_DEC_H: idu_opnd = h_ff;
         eog_pkg::OP_INC_L, eog_pkg::OP_DEC_L: idu_opnd = l_ff;
         eog_pkg::OP_INC_A, eog_pkg::OP_DEC_A: idu_opnd = a_ff;
         default:                              idu_opnd = q_entry.mem_read_value;
      endcase
      idu_dec  = q_entry.kind inside {eog_pkg::OP_DEC_H, eog_pkg::OP_DEC_L,
                                      eog_pkg::OP_DEC_A, eog_pkg::OP_DEC_MEM};
      idu_res  = idu_dec ? idu_opnd - 8'd1 : idu_opnd + 8'd1;
      idu_half = idu_dec ? (idu_opnd[3:0] == 4'h0) : (idu_opnd[3:0] == 4'hF);
   end

   // 16-bit add into HL, with carries out of bits 11 and 15.
   always_comb begin
      add_b   = (q_entry.kind == eog_pkg::OP_ADD_HL_SP) ? sp_ff : hl;
      add_sum = {1'b0, hl} + {1'b0, add_b};
      add_low = {1'b0, hl[11:0]} + {1'b0, add_b[11:0]};
   end

   // Decimal adjust of A.
   always_comb begin
      daa_val = a_ff;
      daa_c   = flags_ff[eog_pkg::FLAG_C];
      if (!flags_ff[eog_pkg::FLAG_N]) begin
         if (flags_ff[eog_pkg::FLAG_C] || (a_ff > eog_pkg::DAA_LIMIT)) begin
            daa_val = daa_val + eog_pkg::DAA_HI_ADJ;
            daa_c   = 1'b1;
         end
         if (flags_ff[eog_pkg::FLAG_H] || (daa_val[3:0] > eog_pkg::DAA_DIGIT_MAX)) begin
            daa_val = daa_val + eog_pkg::DAA_LO_ADJ;
         end
      end else begin
         if (flags_ff[eog_pkg::FLAG_C]) begin
            daa_val = daa_val - eog_pkg::DAA_HI_ADJ;
         end
         if (flags_ff[eog_pkg::FLAG_H]) begin
            daa_val = daa_val - eog_pkg::DAA_LO_ADJ;
         end
      end
   end

   // Operation select.
   always_comb begin
      a_in     = a_ff;
      hl_in    = hl;
      sp_in    = sp_ff;
      flags_in = flags_ff;
      pc_next  = q_entry.pc_in;
      wen      = 1'b0;
      wdata    = 8'h00;
      cyc      = q_entry.cycles;
      case (q_entry.kind)
         eog_pkg::OP_JR: begin
            if (taken) begin
               pc_next = q_entry.jr_target;
               cyc     = eog_pkg::CYC_THREE;
            end
         end
         eog_pkg::OP_LD_HL_IMM: hl_in = q_entry.imm16;
         eog_pkg::OP_LDI_MEM_A: begin
            wen   = 1'b1;
            wdata = a_ff;
            hl_in = hl + 16'd1;
         end
         eog_pkg::OP_LDD_MEM_A: begin
            wen   = 1'b1;
            wdata = a_ff;
            hl_in = hl - 16'd1;
         end
         eog_pkg::OP_INC_HL16: hl_in = hl + 16'd1;
         eog_pkg::OP_DEC_HL16: hl_in = hl - 16'd1;
         eog_pkg::OP_INC_H, eog_pkg::OP_DEC_H: begin
            hl_in                     = {idu_res, l_ff};
            flags_in[eog_pkg::FLAG_Z] = (idu_res == 8'h00);
            flags_in[eog_pkg::FLAG_N] = idu_dec;
            flags_in[eog_pkg::FLAG_H] = idu_half;
         end
         eog_pkg::OP_INC_L, eog_pkg::OP_DEC_L: begin
            hl_in                     = {h_ff, idu_res};
            flags_in[eog_pkg::FLAG_Z] = (idu_res == 8'h00);
            flags_in[eog_pkg::FLAG_N] = idu_dec;
            flags_in[eog_pkg::FLAG_H] = idu_half;
         end
         eog_pkg::OP_INC_A, eog_pkg::OP_DEC_A: begin
            a_in                      = idu_res;
            flags_in[eog_pkg::FLAG_Z] = (idu_res == 8'h00);
            flags_in[eog_pkg::FLAG_N] = idu_dec;
            flags_in[eog_pkg::FLAG_H] = idu_half;
         end
         eog_pkg::OP_INC_MEM, eog_pkg::OP_DEC_MEM: begin
            wen                       = 1'b1;
            wdata                     = idu_res;
            flags_in[eog_pkg::FLAG_Z] = (idu_res == 8'h00);
            flags_in[eog_pkg::FLAG_N] = idu_dec;
            flags_in[eog_pkg::FLAG_H] = idu_half;
         end
         eog_pkg::OP_LD_H_IMM: hl_in = {q_entry.imm8, l_ff};
         eog_pkg::OP_LD_L_IMM: hl_in = {h_ff, q_entry.imm8};
         eog_pkg::OP_DAA: begin
            a_in                      = daa_val;
            flags_in[eog_pkg::FLAG_Z] = (daa_val == 8'h00);
            flags_in[eog_pkg::FLAG_H] = 1'b0;
            flags_in[eog_pkg::FLAG_C] = daa_c;
         end
         eog_pkg::OP_ADD_HL_HL, eog_pkg::OP_ADD_HL_SP: begin
            hl_in                     = add_sum[15:0];
            flags_in[eog_pkg::FLAG_N] = 1'b0;
            flags_in[eog_pkg::FLAG_H] = add_low[12];
            flags_in[eog_pkg::FLAG_C] = add_sum[16];
         end
         eog_pkg::OP_LDI_A_MEM: begin
            a_in  = q_entry.mem_read_value;
            hl_in = hl + 16'd1;
         end
         eog_pkg::OP_LDD_A_MEM: begin
            a_in  = q_entry.mem_read_value;
            hl_in = hl - 16'd1;
         end
         eog_pkg::OP_CPL: begin
            a_in                      = ~a_ff;
            flags_in[eog_pkg::FLAG_N] = 1'b1;
            flags_in[eog_pkg::FLAG_H] = 1'b1;
         end
         eog_pkg::OP_LD_SP_IMM: sp_in = q_entry.imm16;
         eog_pkg::OP_INC_SP:    sp_in = sp_ff + 16'd1;
         eog_pkg::OP_DEC_SP:    sp_in = sp_ff - 16'd1;
         eog_pkg::OP_LD_MEM_IMM: begin
            wen   = 1'b1;
            wdata = q_entry.imm8;
         end
         eog_pkg::OP_SCF: begin
            flags_in[eog_pkg::FLAG_N] = 1'b0;
            flags_in[eog_pkg::FLAG_H] = 1'b0;
            flags_in[eog_pkg::FLAG_C] = 1'b1;
         end
         eog_pkg::OP_CCF: begin
            flags_in[eog_pkg::FLAG_N] = 1'b0;
            flags_in[eog_pkg::FLAG_H] = 1'b0;
            flags_in[eog_pkg::FLAG_C] = !flags_ff[eog_pkg::FLAG_C];
         end
         eog_pkg::OP_LD_A_IMM: a_in = q_entry.imm8;
         default: begin
            cyc = eog_pkg::CYC_NONE;
         end
      endcase
   end

   // Response valid: set on execute, cleared when taken.
   always_comb begin
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         a_ff     <= '0;
         h_ff     <= '0;
         l_ff     <= '0;
         sp_ff    <= '0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            a_ff     <= a_in;
            h_ff     <= hl_in[15:8];
            l_ff     <= hl_in[7:0];
            sp_ff    <= sp_in;
            flags_ff <= flags_in;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         pc_out_ff    <= pc_next;
         mem_addr_ff  <= hl;
         wen_ff       <= wen;
         wdata_ff     <= wdata;
         cyc_ff       <= cyc;
         rec_ff       <= (q_entry.kind != eog_pkg::OP_NONE);
         a_out_ff     <= a_in;
         hl_out_ff    <= hl_in;
         sp_out_ff    <= sp_in;
         flags_out_ff <= flags_in;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.pc_out         = pc_out_ff;
   assign rsp_if.mem_addr       = mem_addr_ff;
   assign rsp_if.mem_write_en   = wen_ff;
   assign rsp_if.mem_write_data = wdata_ff;
   assign rsp_if.machine_cycles = cyc_ff;
   assign rsp_if.recognized     = rec_ff;
   assign rsp_if.accumulator    = a_out_ff;
   assign rsp_if.hl_pair        = hl_out_ff;
   assign rsp_if.stack_ptr      = sp_out_ff;
   assign rsp_if.flag_bits      = flags_out_ff;

endmodule

/* rtl/core/exec_opcode_group_20_3f.sv */
// An accepted item is decoded into the queue at the accepting edge and is executed
// into the response register at the edge on which the execute stage pops it.
// Throughput: one item per cycle while the response channel does not stall; the
// execute stage, which also holds A, HL, SP and flags, sets that rate.
// Reset is synchronous and active high: it empties the queue, drops the
// response and clears A, H, L, SP and the flags to zero.
module exec_opcode_group_20_3f (
   input  logic       clock,
   input  logic       reset,
   eog_req_if.sink    req_if,
   eog_rsp_if.source  rsp_if
);

   logic                 push;
   logic                 queue_full;
   logic                 pop;
   logic                 q_valid;
   eog_pkg::q_entry_type push_entry;
   eog_pkg::q_entry_type q_entry;

   // Decode side.
   eog_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   eog_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   // Execute side.
   eog_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .pop     (pop),
      .rsp_if  (rsp_if)
   );

endmodule

/* rtl/core/eog_checker.sv */
// Port-level checks on the response channel of exec_opcode_group_20_3f and
// the bind that attaches them. Depends on assert_macros.svh.
`include "assert_macros.svh"

module eog_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pc_out,
   input logic [15:0] rsp_mem_addr,
   input logic        rsp_mem_write_en,
   input logic [7:0]  rsp_mem_write_data,
   input logic [1:0]  rsp_machine_cycles,
   input logic        rsp_recognized,
   input logic [7:0]  rsp_accumulator,
   input logic [15:0] rsp_hl_pair,
   input logic [15:0] rsp_stack_ptr,
   input logic [3:0]  rsp_flag_bits
);

   // A stalled item keeps its contents.
   `EOG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pc_out) && $stable(rsp_mem_addr) && $stable(rsp_mem_write_en) && $stable(rsp_mem_write_data) && $stable(rsp_machine_cycles) && $stable(rsp_recognized) && $stable(rsp_accumulator) && $stable(rsp_hl_pair) && $stable(rsp_stack_ptr) && $stable(rsp_flag_bits))

   // An unknown opcode takes no cycles and writes nothing.
   `EOG_ASSERT_IMPLY(a_unrec_idle, clock, reset, rsp_valid && !rsp_recognized, rsp_machine_cycles == 2'd0 && !rsp_mem_write_en)

   // Every executed opcode takes at least one cycle.
   `EOG_ASSERT_IMPLY(a_rec_cycles, clock, reset, rsp_valid && rsp_recognized, rsp_machine_cycles != 2'd0)

   // Write data reads as zero when nothing is stored.
   `EOG_ASSERT_IMPLY(a_wdata_zero, clock, reset, rsp_valid && !rsp_mem_write_en, rsp_mem_write_data == 8'h00)

endmodule

bind exec_opcode_group_20_3f eog_checker u_eog_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_pc_out         (rsp_if.pc_out),
   .rsp_mem_addr       (rsp_if.mem_addr),
   .rsp_mem_write_en   (rsp_if.mem_write_en),
   .rsp_mem_write_data (rsp_if.mem_write_data),
   .rsp_machine_cycles (rsp_if.machine_cycles),
   .rsp_recognized     (rsp_if.recognized),
   .rsp_accumulator    (rsp_if.accumulator),
   .rsp_hl_pair        (rsp_if.hl_pair),
   .rsp_stack_ptr      (rsp_if.stack_ptr),
   .rsp_flag_bits      (rsp_if.flag_bits)
);

/* tb/sv/exec_opcode_group_20_3f_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for exec_opcode_group_20_3f: directed corner items, then random
// instruction streams, with a scoreboard class that predicts every response and compares it.
// Depends on eog_pkg and the eog_req_if / eog_rsp_if interfaces.
module exec_opcode_group_20_3f_tb;

   localparam int RANDOM_ITEMS     = 820;
   localparam int LONG_HOLD_AFTER  = 400;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES    = 8;

   // One instruction as offered on the request channel.
   typedef struct {
      logic [7:0]  action;
      logic [7:0]  imm8;
      logic [15:0] imm16;
      logic [15:0] pc_in;
      logic [7:0]  mem_read_value;
   } instr_type;

   // One response as seen on the result channel.
   typedef struct {
      logic [15:0] pc_out;
      logic [15:0] mem_addr;
      logic        mem_write_en;
      logic [7:0]  mem_write_data;
      logic [1:0]  machine_cycles;
      logic        recognized;
      logic [7:0]  accumulator;
      logic [15:0] hl_pair;
      logic [15:0] stack_ptr;
      logic [3:0]  flag_bits;
   } outcome_type;

   // Keeps a private copy of A, HL, SP and the flags, predicts the response of each
   // accepted item and checks responses against the oldest prediction.
   class row_exec_scoreboard;
      logic [7:0]  acc;
      logic [7:0]  hi_byte;
      logic [7:0]  lo_byte;
      logic [15:0] stack;
      logic [3:0]  zn_hc;
      outcome_type due[$];
      int          errors;

      function new();
         acc     = '0;
         hi_byte = '0;
         lo_byte = '0;
         stack   = '0;
         zn_hc   = '0;
         errors  = 0;
      endfunction

      function bit idle();
         return due.size() == 0;
      endfunction

      // Byte increment; carry is untouched, half carry comes out of bit 3.
      function logic [7:0] bump_up(logic [7:0] v);
         logic [7:0] r;
         r = v + 8'd1;
         zn_hc[eog_pkg::FLAG_Z] = (r == 8'd0);
         zn_hc[eog_pkg::FLAG_N] = 1'b0;
         zn_hc[eog_pkg::FLAG_H] = (v[3:0] == 4'hF);
         return r;
      endfunction

      // Byte decrement; half carry is the borrow into bit 4.
      function logic [7:0] bump_down(logic [7:0] v);
         logic [7:0] r;
         r = v - 8'd1;
         zn_hc[eog_pkg::FLAG_Z] = (r == 8'd0);
         zn_hc[eog_pkg::FLAG_N] = 1'b1;
         zn_hc[eog_pkg::FLAG_H] = (v[3:0] == 4'h0);
         return r;
      endfunction

      // Sixteen-bit add into HL; zero flag is kept.
      function logic [15:0] add_word(logic [15:0] a, logic [15:0] b);
         logic [16:0] sum;
         logic [12:0] low_sum;
         sum     = {1'b0, a} + {1'b0, b};
         low_sum = {1'b0, a[11:0]} + {1'b0, b[11:0]};
         zn_hc[eog_pkg::FLAG_N] = 1'b0;
         zn_hc[eog_pkg::FLAG_H] = low_sum[12];
         zn_hc[eog_pkg::FLAG_C] = sum[16];
         return sum[15:0];
      endfunction

      // Decimal adjust of A after an add or a subtract.
      function void decimal_adjust();
         logic [7:0] a;
         a = acc;
         if (!zn_hc[eog_pkg::FLAG_N]) begin
            if (zn_hc[eog_pkg::FLAG_C] || a > eog_pkg::DAA_LIMIT) begin
               a = a + eog_pkg::DAA_HI_ADJ;
               zn_hc[eog_pkg::FLAG_C] = 1'b1;
            end
            if (zn_hc[eog_pkg::FLAG_H] || a[3:0] > eog_pkg::DAA_DIGIT_MAX)
               a = a + eog_pkg::DAA_LO_ADJ;
         end else begin
            if (zn_hc[eog_pkg::FLAG_C])
               a = a - eog_pkg::DAA_HI_ADJ;
            if (zn_hc[eog_pkg::FLAG_H])
               a = a - eog_pkg::DAA_LO_ADJ;
         end
         acc = a;
         zn_hc[eog_pkg::FLAG_Z] = (a == 8'd0);
         zn_hc[eog_pkg::FLAG_H] = 1'b0;
      endfunction

      // Execute one accepted item on the private state and queue its response.
      function void note_item(instr_type it);
         outcome_type want;
         logic [15:0] hl;
         logic [15:0] offset;
         bit          taken;
         hl = {hi_byte, lo_byte};
         offset = {{8{it.imm8[7]}}, it.imm8};
         taken = 1'b0;
         want.pc_out         = it.pc_in;
         want.mem_addr       = hl;
         want.mem_write_en   = 1'b0;
         want.mem_write_data = '0;
         want.machine_cycles = eog_pkg::CYC_NONE;
         want.recognized     = (it.action >= eog_pkg::OPC_JR_NZ) &&
                               (it.action <= eog_pkg::OPC_CCF);
         case (it.action)
            eog_pkg::OPC_JR_NZ, eog_pkg::OPC_JR_Z, eog_pkg::OPC_JR_NC,
            eog_pkg::OPC_JR_C: begin
               case (it.action)
                  eog_pkg::OPC_JR_NZ: taken = !zn_hc[eog_pkg::FLAG_Z];
                  eog_pkg::OPC_JR_Z:  taken = zn_hc[eog_pkg::FLAG_Z];
                  eog_pkg::OPC_JR_NC: taken = !zn_hc[eog_pkg::FLAG_C];
                  default:            taken = zn_hc[eog_pkg::FLAG_C];
               endcase
               if (taken) begin
                  want.pc_out = it.pc_in + offset;
                  want.machine_cycles = eog_pkg::CYC_THREE;
               end else begin
                  want.machine_cycles = eog_pkg::CYC_TWO;
               end
            end
            eog_pkg::OPC_LD_HL_IMM: begin
               hl = it.imm16;
               want.machine_cycles = eog_pkg::CYC_THREE;
            end
            eog_pkg::OPC_LDI_MEM_A, eog_pkg::OPC_LDD_MEM_A: begin
               want.mem_write_en = 1'b1;
               want.mem_write_data = acc;
               hl = (it.action == eog_pkg::OPC_LDI_MEM_A) ? hl + 16'd1 : hl - 16'd1;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_INC_HL16: begin
               hl = hl + 16'd1;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_DEC_HL16: begin
               hl = hl - 16'd1;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_INC_H: begin
               hl[15:8] = bump_up(hl[15:8]);
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_DEC_H: begin
               hl[15:8] = bump_down(hl[15:8]);
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_INC_L: begin
               hl[7:0] = bump_up(hl[7:0]);
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_DEC_L: begin
               hl[7:0] = bump_down(hl[7:0]);
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_LD_H_IMM: begin
               hl[15:8] = it.imm8;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_LD_L_IMM: begin
               hl[7:0] = it.imm8;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_DAA: begin
               decimal_adjust();
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_ADD_HL_HL: begin
               hl = add_word(hl, hl);
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_ADD_HL_SP: begin
               hl = add_word(hl, stack);
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_LDI_A_MEM, eog_pkg::OPC_LDD_A_MEM: begin
               acc = it.mem_read_value;
               hl = (it.action == eog_pkg::OPC_LDI_A_MEM) ? hl + 16'd1 : hl - 16'd1;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_CPL: begin
               acc = ~acc;
               zn_hc[eog_pkg::FLAG_N] = 1'b1;
               zn_hc[eog_pkg::FLAG_H] = 1'b1;
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_LD_SP_IMM: begin
               stack = it.imm16;
               want.machine_cycles = eog_pkg::CYC_THREE;
            end
            eog_pkg::OPC_INC_SP: begin
               stack = stack + 16'd1;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_DEC_SP: begin
               stack = stack - 16'd1;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            eog_pkg::OPC_INC_MEM: begin
               want.mem_write_en = 1'b1;
               want.mem_write_data = bump_up(it.mem_read_value);
               want.machine_cycles = eog_pkg::CYC_THREE;
            end
            eog_pkg::OPC_DEC_MEM: begin
               want.mem_write_en = 1'b1;
               want.mem_write_data = bump_down(it.mem_read_value);
               want.machine_cycles = eog_pkg::CYC_THREE;
            end
            eog_pkg::OPC_LD_MEM_IMM: begin
               want.mem_write_en = 1'b1;
               want.mem_write_data = it.imm8;
               want.machine_cycles = eog_pkg::CYC_THREE;
            end
            eog_pkg::OPC_SCF, eog_pkg::OPC_CCF: begin
               zn_hc[eog_pkg::FLAG_C] = (it.action == eog_pkg::OPC_SCF) ? 1'b1 :
                                        !zn_hc[eog_pkg::FLAG_C];
               zn_hc[eog_pkg::FLAG_N] = 1'b0;
               zn_hc[eog_pkg::FLAG_H] = 1'b0;
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_INC_A: begin
               acc = bump_up(acc);
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_DEC_A: begin
               acc = bump_down(acc);
               want.machine_cycles = eog_pkg::CYC_ONE;
            end
            eog_pkg::OPC_LD_A_IMM: begin
               acc = it.imm8;
               want.machine_cycles = eog_pkg::CYC_TWO;
            end
            default: begin
            end
         endcase
         hi_byte = hl[15:8];
         lo_byte = hl[7:0];
         want.accumulator = acc;
         want.hl_pair     = hl;
         want.stack_ptr   = stack;
         want.flag_bits   = zn_hc;
         due.push_back(want);
      endfunction

      function void compare(string field, logic [15:0] want_v, logic [15:0] got_v);
         if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want_v, got_v);
            errors++;
         end
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_result(outcome_type got);
         outcome_type want;
         if (due.size() == 0) begin
            $error("response item arrived with no instruction outstanding");
            errors++;
            return;
         end
         want = due.pop_front();
         compare("pc_out", want.pc_out, got.pc_out);
         compare("mem_addr", want.mem_addr, got.mem_addr);
         compare("mem_write_en", 16'(want.mem_write_en), 16'(got.mem_write_en));
         compare("mem_write_data", 16'(want.mem_write_data), 16'(got.mem_write_data));
         compare("machine_cycles", 16'(want.machine_cycles), 16'(got.machine_cycles));
         compare("recognized", 16'(want.recognized), 16'(got.recognized));
         compare("accumulator", 16'(want.accumulator), 16'(got.accumulator));
         compare("hl_pair", want.hl_pair, got.hl_pair);
         compare("stack_ptr", want.stack_ptr, got.stack_ptr);
         compare("flag_bits", 16'(want.flag_bits), 16'(got.flag_bits));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   eog_req_if req_if ();
   eog_rsp_if rsp_if ();

   exec_opcode_group_20_3f uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   row_exec_scoreboard exec_sb;
   int sent_items   = 0;
   int results_seen = 0;

   always #10 clock = ~clock;

   // Offer one instruction after a gap, random or in some stretches of items zero, and wait until it is taken. Ready is
   // sampled at the falling edge, where it is settled for the next rising edge.
   task automatic issue_instr(input instr_type it);
      int gap;
      bit accepted;
      gap = (((sent_items / 64) % 4) == 1) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.action         <= it.action;
      req_if.imm8           <= it.imm8;
      req_if.imm16          <= it.imm16;
      req_if.pc_in          <= it.pc_in;
      req_if.mem_read_value <= it.mem_read_value;
      do begin
         @(negedge clock);
         accepted = req_if.ready;
         @(posedge clock);
      end while (!accepted);
      exec_sb.note_item(it);
      sent_items++;
   endtask

   // Stop offering and wait until every predicted response has been checked.
   task automatic await_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (!exec_sb.idle());
   endtask

   function automatic instr_type random_instr(logic [7:0] action);
      instr_type it;
      it.action         = action;
      it.imm8           = 8'($urandom_range(0, 255));
      it.imm16          = 16'($urandom_range(0, 65535));
      it.pc_in          = 16'($urandom_range(0, 65535));
      it.mem_read_value = 8'($urandom_range(0, 255));
      return it;
   endfunction

   // Four operand corners: immediates all zeros, all ones or the two sign edges; pc_in and mem_read_value inverted.
   function automatic instr_type corner_instr(logic [7:0] action, int corner);
      instr_type it;
      it.action = action;
      case (corner % 4)
         0: begin
            it.imm8 = 8'h00; it.imm16 = 16'h0000; it.pc_in = 16'hFFFF; it.mem_read_value = 8'hFF;
         end
         1: begin
            it.imm8 = 8'hFF; it.imm16 = 16'hFFFF; it.pc_in = 16'h0000; it.mem_read_value = 8'h00;
         end
         2: begin
            it.imm8 = 8'h7F; it.imm16 = 16'h7FFF; it.pc_in = 16'h8000; it.mem_read_value = 8'h80;
         end
         default: begin
            it.imm8 = 8'h80; it.imm16 = 16'h8000; it.pc_in = 16'h7FFF; it.mem_read_value = 8'h7F;
         end
      endcase
      return it;
   endfunction

   // An instruction that leaves A and the flags in an interesting state before DAA.
   function automatic logic [7:0] daa_prelude();
      case ($urandom_range(0, 6))
         0: return eog_pkg::OPC_INC_A;
         1: return eog_pkg::OPC_DEC_A;
         2: return eog_pkg::OPC_SCF;
         3: return eog_pkg::OPC_CCF;
         4: return eog_pkg::OPC_ADD_HL_HL;
         5: return eog_pkg::OPC_ADD_HL_SP;
         default: return eog_pkg::OPC_CPL;
      endcase
   endfunction

   // Request side: reset, directed corners, then random instruction streams.
   initial begin : req_side
      int idx;
      int n_rand;
      int pick;
      bit paused;
      exec_sb = new();
      req_if.valid          <= 1'b0;
      req_if.action         <= '0;
      req_if.imm8           <= '0;
      req_if.imm16          <= '0;
      req_if.pc_in          <= '0;
      req_if.mem_read_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Opcodes outside the row, including both neighbors of its bounds.
      issue_instr(corner_instr('0, 0));
      issue_instr(corner_instr('1, 1));
      issue_instr(corner_instr(8'(eog_pkg::OPC_JR_NZ - 1), 2));
      issue_instr(corner_instr(8'(eog_pkg::OPC_CCF + 1), 3));
      // Every opcode of the row once, with operands at the corners.
      for (idx = eog_pkg::OPC_JR_NZ; idx <= eog_pkg::OPC_CCF; idx++)
         issue_instr(corner_instr(8'(idx), idx));
      await_results();

      // Random part: mostly row opcodes, some DAA sequences, some unrecognized noise.
      n_rand = 0;
      paused = 1'b0;
      while (n_rand < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            issue_instr(random_instr(eog_pkg::OPC_LD_A_IMM));
            issue_instr(random_instr(daa_prelude()));
            issue_instr(random_instr(eog_pkg::OPC_DAA));
            n_rand += 3;
         end else if (pick < 90) begin
            issue_instr(random_instr(8'($urandom_range(eog_pkg::OPC_JR_NZ, eog_pkg::OPC_CCF))));
            n_rand++;
         end else begin
            issue_instr(random_instr(8'($urandom_range(0, 255))));
            n_rand++;
         end
         // Once in the middle, let the block run completely dry.
         if (!paused && n_rand >= RANDOM_ITEMS / 2) begin
            await_results();
            paused = 1'b1;
         end
      end

      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (exec_sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Response side: random stalls, a zero-stall stretch now and then, and one long hold.
   initial begin : rsp_side
      int stall;
      bit took;
      outcome_type got;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (results_seen == LONG_HOLD_AFTER)
            stall = LONG_HOLD_CYCLES;
         else if (((results_seen / 50) % 4) == 2)
            stall = 0;
         else
            stall = $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do begin
            @(negedge clock);
            took                = rsp_if.valid;
            got.pc_out          = rsp_if.pc_out;
            got.mem_addr        = rsp_if.mem_addr;
            got.mem_write_en    = rsp_if.mem_write_en;
            got.mem_write_data  = rsp_if.mem_write_data;
            got.machine_cycles  = rsp_if.machine_cycles;
            got.recognized      = rsp_if.recognized;
            got.accumulator     = rsp_if.accumulator;
            got.hl_pair         = rsp_if.hl_pair;
            got.stack_ptr       = rsp_if.stack_ptr;
            got.flag_bits       = rsp_if.flag_bits;
            @(posedge clock);
         end while (took !== 1'b1);
         exec_sb.check_result(got);
         results_seen++;
      end
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/eog_pkg.sv
rtl/core/eog_ifs.sv
rtl/core/eog_front.sv
rtl/core/eog_queue.sv
rtl/core/eog_back.sv
rtl/core/exec_opcode_group_20_3f.sv
rtl/core/eog_checker.sv
tb/sv/exec_opcode_group_20_3f_tb.sv
